FILE: rtl/core/cossim_pkg.sv
package cossim_pkg;

    // Field widths of the request and result channels
    localparam int ELEM_W      = 16;
    localparam int SIM_W       = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int DEF_MAX_LEN = 4096;

    // Unity in unsigned Q1.15
    localparam logic [SIM_W-1:0] SIM_ONE = 16'h8000;

    // Quotient bits produced by the divider, one per step
    localparam int QUOT_STEPS = SIM_W;

    typedef enum logic [2:0] {
        S_ACC,
        S_SETTLE,
        S_CHECK,
        S_MUL,
        S_SQRT,
        S_DIV,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic acc;
        logic mul_init;
        logic mul_step;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic quot_clr;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pos;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/cossim_if.sv
interface cossim_req_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [cossim_pkg::ELEM_W-1:0]     elem_a;
    logic signed [cossim_pkg::ELEM_W-1:0]     elem_b;
    logic                                     last_pair;

    modport source (output valid, output elem_a, output elem_b, output last_pair,
                    input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last_pair,
                    output ready);
endinterface

interface cossim_res_if;
    logic                            valid;
    logic                            ready;
    logic [cossim_pkg::SIM_W-1:0]    similarity;
    logic                            too_long;

    modport source (output valid, output similarity, output too_long, input ready);
    modport sink   (input valid, input similarity, input too_long, output ready);
endinterface

FILE: rtl/core/cossim_ctrl.sv
module cossim_ctrl #(
    parameter int MAX_LEN = cossim_pkg::DEF_MAX_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_last,
    output logic              o_req_ready,
    input  cossim_pkg::t_sts  i_sts,
    output cossim_pkg::t_cmd  o_cmd
);

    localparam int NORM_W = cossim_pkg::PROD_W - 1 + $clog2(MAX_LEN);
    localparam int STEP_W = $clog2(NORM_W);
    localparam logic [STEP_W-1:0] NORM_LAST = STEP_W'(NORM_W - 1);
    localparam logic [STEP_W-1:0] QUOT_LAST = STEP_W'(cossim_pkg::QUOT_STEPS - 1);

    cossim_pkg::t_state r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;

    // Hold state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cossim_pkg::S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Sequence accumulate, multiply, root, divide and hand-off; a non-positive dot product goes straight to hand-off
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            cossim_pkg::S_ACC: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_req_last) begin
                        n_state = cossim_pkg::S_SETTLE;
                    end
                end
            end
            cossim_pkg::S_SETTLE: begin
                n_state = cossim_pkg::S_CHECK;
            end
            cossim_pkg::S_CHECK: begin
                n_step = '0;
                if (i_sts.pos) begin
                    o_cmd.mul_init = 1'b1;
                    n_state        = cossim_pkg::S_MUL;
                end else begin
                    o_cmd.quot_clr = 1'b1;
                    n_state        = cossim_pkg::S_DONE;
                end
            end
            cossim_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == NORM_LAST) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_step          = '0;
                    n_state         = cossim_pkg::S_SQRT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            cossim_pkg::S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == NORM_LAST) begin
                    o_cmd.div_init = 1'b1;
                    n_step         = '0;
                    n_state        = cossim_pkg::S_DIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            cossim_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == QUOT_LAST) begin
                    n_step  = '0;
                    n_state = cossim_pkg::S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            cossim_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = cossim_pkg::S_ACC;
                end
            end
            default: begin
                n_state = cossim_pkg::S_ACC;
                n_step  = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/cossim_dp.sv
module cossim_dp #(
    parameter int MAX_LEN = cossim_pkg::DEF_MAX_LEN
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [cossim_pkg::ELEM_W-1:0] i_elem_a,
    input  logic signed [cossim_pkg::ELEM_W-1:0] i_elem_b,
    input  cossim_pkg::t_cmd                     i_cmd,
    output cossim_pkg::t_sts                     o_sts,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic [cossim_pkg::SIM_W-1:0]         o_similarity,
    output logic                                 o_too_long
);

    localparam int PROD_W = cossim_pkg::PROD_W;
    localparam int NORM_W = PROD_W - 1 + $clog2(MAX_LEN);
    localparam int DOT_W  = NORM_W + 2;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int SIM_W  = cossim_pkg::SIM_W;

    // Product stage and accumulators
    logic signed [PROD_W-1:0]   w_pab, w_paa, w_pbb;
    logic signed [PROD_W-1:0]   r_pab;
    logic [PROD_W-2:0]          r_paa, r_pbb;
    logic                       r_padd;
    logic signed [DOT_W-1:0]    r_dot;
    logic [NORM_W-1:0]          r_na, r_nb;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_ovf;

    // Norm product, root and quotient
    logic [2*NORM_W-1:0]        r_prod;
    logic [NORM_W-1:0]          r_mplr;
    logic [NORM_W+1:0]          r_srem;
    logic [NORM_W-1:0]          r_root;
    logic [NORM_W:0]            r_drem;
    logic [SIM_W-1:0]           r_quot;

    // Output register
    logic                       r_ovalid;
    logic [SIM_W-1:0]           r_sim;
    logic                       r_tl;

    logic [2*NORM_W-1:0]        w_addend;
    logic [NORM_W+3:0]          w_stry, w_strial;
    logic                       w_sbit;
    logic                       w_dge;
    logic [NORM_W:0]            w_dnext;
    logic [SIM_W-1:0]           w_clamp;

    assign w_pab = i_elem_a * i_elem_b;
    assign w_paa = i_elem_a * i_elem_a;
    assign w_pbb = i_elem_b * i_elem_b;

    // Shift-add multiply step over the bits of norm b
    assign w_addend = r_mplr[NORM_W-1] ? (2*NORM_W)'(r_na) : '0;

    // Restoring root step: two radicand bits per step
    assign w_stry   = {r_srem, r_prod[2*NORM_W-1 -: 2]};
    assign w_strial = (NORM_W + 4)'({r_root, 2'b01});
    assign w_sbit   = (w_stry >= w_strial);

    // Restoring divide step: one quotient bit per step
    assign w_dge   = (r_drem >= {1'b0, r_root});
    assign w_dnext = w_dge ? (r_drem - {1'b0, r_root}) : r_drem;

    assign w_clamp = (r_quot > cossim_pkg::SIM_ONE) ? cossim_pkg::SIM_ONE : r_quot;

    assign o_sts.pos      = !r_dot[DOT_W-1] && (r_dot != '0) && (r_na != '0) && (r_nb != '0);
    assign o_sts.out_free = !r_ovalid || i_res_ready;

    assign o_res_valid  = r_ovalid;
    assign o_similarity = r_sim;
    assign o_too_long   = r_tl;

    // Count each request and add its products in the cycle after capture; pairs past MAX_LEN only set the overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_padd <= 1'b0;
            r_dot  <= '0;
            r_na   <= '0;
            r_nb   <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_padd <= 1'b0;
            if (i_cmd.acc) begin
                if (r_cnt < CNT_W'(MAX_LEN)) begin
                    r_padd <= 1'b1;
                    r_cnt  <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_padd) begin
                r_dot <= r_dot + DOT_W'(r_pab);
                r_na  <= r_na + NORM_W'(r_paa);
                r_nb  <= r_nb + NORM_W'(r_pbb);
            end
            if (i_cmd.emit) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    // Hold product terms for the add stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_pab <= w_pab;
            r_paa <= w_paa[PROD_W-2:0];
            r_pbb <= w_pbb[PROD_W-2:0];
        end
    end

    // Advance multiply, root and divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_init) begin
            r_prod <= '0;
            r_mplr <= r_nb;
        end else if (i_cmd.mul_step) begin
            r_prod <= {r_prod[2*NORM_W-2:0], 1'b0} + w_addend;
            r_mplr <= {r_mplr[NORM_W-2:0], 1'b0};
        end else if (i_cmd.sqrt_step) begin
            r_prod <= {r_prod[2*NORM_W-3:0], 2'b00};
        end

        if (i_cmd.sqrt_init) begin
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_srem <= w_sbit ? (NORM_W + 2)'(w_stry - w_strial) : (NORM_W + 2)'(w_stry);
            r_root <= {r_root[NORM_W-2:0], w_sbit};
        end

        if (i_cmd.div_init) begin
            r_drem <= {1'b0, r_dot[NORM_W-1:0]};
        end else if (i_cmd.div_step) begin
            r_drem <= {w_dnext[NORM_W-1:0], 1'b0};
        end

        if (i_cmd.div_init || i_cmd.quot_clr) begin
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[SIM_W-2:0], w_dge};
        end
    end

    // Load the output register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_sim <= w_clamp;
            r_tl  <= r_ovf;
        end
    end

endmodule

FILE: rtl/core/cosine_similarity_clamped.sv
// Channel   Direction  Payload                          Accepted when
// i_req     in         elem_a, elem_b, last_pair        valid && ready
// o_res     out        similarity, too_long             valid && ready
//
// Element pairs are taken one per cycle while the block is accumulating. After the final pair,
// ready stays low through a bit-serial multiply of the two NORM_W-bit norms (NORM_W =
// 31 + clog2(MAX_LEN)), a bit-serial square root and a 16-step restoring divide, run in turn,
// with the root reusing the product register as its radicand. A zero or negative dot product
// skips all three and yields zero. Reset is synchronous and clears accumulators and output valid.
// A result waiting on o_res does not stall input until the next one is ready.
module cosine_similarity_clamped #(
    parameter int MAX_LEN = cossim_pkg::DEF_MAX_LEN
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cossim_req_if.sink     i_req,
    cossim_res_if.source   o_res
);

    cossim_pkg::t_cmd w_cmd;
    cossim_pkg::t_sts w_sts;

    cossim_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_last  (i_req.last_pair),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cossim_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_a     (i_req.elem_a),
        .i_elem_b     (i_req.elem_b),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_res_valid  (o_res.valid),
        .i_res_ready  (o_res.ready),
        .o_similarity (o_res.similarity),
        .o_too_long   (o_res.too_long)
    );

endmodule

FILE: rtl/core/cossim_checker.sv
module cossim_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_req_last,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [cossim_pkg::SIM_W-1:0]  i_similarity
);

    // A delivered similarity never exceeds unity
    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_similarity <= cossim_pkg::SIM_ONE))
        else $error("similarity above unity");

    // The final pair of a vector starts the reduction and blocks input
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && i_req_last) |=> !i_req_ready)
        else $error("request accepted during reduction");

    // No result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_similarity)))
        else $error("stalled result dropped or changed");

endmodule

bind cosine_similarity_clamped cossim_checker u_cossim_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_last   (i_req.last_pair),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_similarity (o_res.similarity)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int DOT_W            = 45;
    localparam int NORM_W           = 43;
    localparam int ROOT_W           = 48;
    localparam int PHASE_PAIRS      = 415;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 120;
    localparam int N_DIRECTED       = 19;

    // Content patterns for generated vectors
    localparam int VEC_RANDOM   = 0;
    localparam int VEC_SAME     = 1;
    localparam int VEC_OPPOSITE = 2;
    localparam int VEC_TINY     = 3;
    localparam int VEC_NEAR     = 4;
    localparam int VEC_EXTREME  = 5;
    localparam int VEC_ZERO_A   = 6;
    localparam int VEC_ALL_MIN  = 7;

    typedef struct packed {
        logic [cossim_pkg::SIM_W-1:0] similarity;
        logic                         too_long;
    } t_sim_result;

    typedef struct {
        logic signed [cossim_pkg::ELEM_W-1:0] a;
        logic signed [cossim_pkg::ELEM_W-1:0] b;
        logic                                 last;
        bit                                   fixed;
        t_sim_result                          res;
    } t_pair_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cossim_req_if req_if ();
    cossim_res_if res_if ();

    cosine_similarity_clamped dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Running sums of the vectors in flight, mirrored from the block
    logic signed [DOT_W-1:0]  run_dot;
    logic [NORM_W-1:0]        run_norm_a;
    logic [NORM_W-1:0]        run_norm_b;
    int unsigned              run_count;
    bit                       run_over;

    t_sim_result sim_expect_q[$];

    int err_count     = 0;
    int pairs_sent    = 0;
    int vectors_sent  = 0;
    int results_seen  = 0;
    int over_len_seen = 0;
    int unity_seen    = 0;
    int zero_seen     = 0;
    int src_idle_pct  = 28;
    int sink_idle_pct = 72;
    bit hold_sink     = 1'b0;

    // Directed requests; fixed rows carry a result readable at a glance
    t_pair_row dir_rows [N_DIRECTED] = '{
        '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{16'h0000, 1'b0}},
        '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, '{cossim_pkg::SIM_ONE, 1'b0}},
        '{16'sh8000, 16'sh8000, 1'b1, 1'b1, '{cossim_pkg::SIM_ONE, 1'b0}},
        '{16'sh8000, 16'sh7FFF, 1'b1, 1'b1, '{16'h0000, 1'b0}},
        '{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, '{16'h0000, 1'b0}},
        '{16'sh0001, 16'sh0001, 1'b1, 1'b1, '{cossim_pkg::SIM_ONE, 1'b0}},
        '{16'sh0001, 16'sh0000, 1'b1, 1'b1, '{16'h0000, 1'b0}},
        '{16'sh0000, 16'shFFFF, 1'b1, 1'b1, '{16'h0000, 1'b0}},
        '{16'sh0001, 16'sh0000, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{16'sh0000, 16'sh0001, 1'b1, 1'b1, '{16'h0000, 1'b0}},
        '{16'sh0001, 16'sh0001, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{16'sh0002, 16'sh0001, 1'b1, 1'b0, '{16'h0000, 1'b0}},
        '{16'sd100,  16'sd200,  1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{16'sd300,  -16'sd50,  1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{-16'sd7000, 16'sd12345, 1'b1, 1'b0, '{16'h0000, 1'b0}},
        '{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, '{16'h0000, 1'b0}},
        '{16'sd5,    16'sd5,    1'b1, 1'b0, '{16'h0000, 1'b0}},
        '{16'shFFFF, 16'shFFFF, 1'b1, 1'b1, '{cossim_pkg::SIM_ONE, 1'b0}}
    };

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Limit
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void clear_sums();
        run_dot    = '0;
        run_norm_a = '0;
        run_norm_b = '0;
        run_count  = 0;
        run_over   = 1'b0;
    endfunction

    // Fold one pair into the sums; on the last pair compute the similarity
    function automatic bit fold_pair(input logic signed [cossim_pkg::ELEM_W-1:0] a,
                                     input logic signed [cossim_pkg::ELEM_W-1:0] b,
                                     input logic last, output t_sim_result res);
        logic signed [2*cossim_pkg::ELEM_W-1:0] p_ab;
        logic signed [2*cossim_pkg::ELEM_W-1:0] p_aa;
        logic signed [2*cossim_pkg::ELEM_W-1:0] p_bb;
        logic [95:0]                            prod;
        logic [95:0]                            sq;
        logic [ROOT_W-1:0]                      root;
        logic [ROOT_W-1:0]                      cand;
        logic [63:0]                            num;
        logic [63:0]                            quo;
        p_ab = a * b;
        p_aa = a * a;
        p_bb = b * b;
        res  = '0;
        quo  = '0;
        if (run_count < cossim_pkg::DEF_MAX_LEN) begin
            run_dot    = run_dot + p_ab;
            run_norm_a = run_norm_a + NORM_W'(unsigned'(p_aa));
            run_norm_b = run_norm_b + NORM_W'(unsigned'(p_bb));
            run_count++;
        end else begin
            // pairs past the length limit only raise the flag
            run_over = 1'b1;
        end
        if (!last) begin
            return 1'b0;
        end
        if (run_dot > 0 && run_norm_a != '0 && run_norm_b != '0) begin
            prod = 96'(run_norm_a) * 96'(run_norm_b);
            root = '0;
            // floor of the square root, one bit at a time from the top
            for (int i = ROOT_W - 1; i >= 0; i--) begin
                cand = root | (ROOT_W'(1) << i);
                sq   = 96'(cand) * 96'(cand);
                if (sq <= prod) begin
                    root = cand;
                end
            end
            if (root != '0) begin
                num = 64'(run_dot) << 15;
                quo = num / 64'(root);
            end
            res.similarity = (quo > 64'(cossim_pkg::SIM_ONE)) ? cossim_pkg::SIM_ONE
                                                               : quo[cossim_pkg::SIM_W-1:0];
        end
        res.too_long = run_over;
        clear_sums();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_result(input t_sim_result got);
        t_sim_result want;
        results_seen++;
        if (got.too_long) over_len_seen++;
        if (got.similarity == cossim_pkg::SIM_ONE) unity_seen++;
        if (got.similarity == '0) zero_seen++;
        if (sim_expect_q.size() == 0) begin
            report_mismatch("result with no request pending", got.similarity, -1);
        end else begin
            want = sim_expect_q.pop_front();
            if (got.similarity !== want.similarity)
                report_mismatch("similarity", got.similarity, want.similarity);
            if (got.too_long !== want.too_long)
                report_mismatch("too_long", got.too_long, want.too_long);
        end
    endtask

    // Result side: check accepted results, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            check_result('{res_if.similarity, res_if.too_long});
        end
        if (hold_sink) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Offer one pair, wait for the handshake, then record the expectation
    task automatic send_pair(input logic signed [cossim_pkg::ELEM_W-1:0] a,
                             input logic signed [cossim_pkg::ELEM_W-1:0] b,
                             input logic last, input bit fixed,
                             input t_sim_result fixed_res);
        t_sim_result pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.elem_a    <= a;
        req_if.elem_b    <= b;
        req_if.last_pair <= last;
        do @(posedge i_clk); while (!req_if.ready);
        pairs_sent++;
        if (fold_pair(a, b, last, pred)) begin
            if (fixed) begin
                pred = fixed_res;
            end
            sim_expect_q = {sim_expect_q, pred};
        end
    endtask

    function automatic logic signed [cossim_pkg::ELEM_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'sh0001;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Send one whole vector with the chosen content pattern
    task automatic send_vector(input int len, input int pattern);
        logic signed [cossim_pkg::ELEM_W-1:0] a;
        logic signed [cossim_pkg::ELEM_W-1:0] b;
        for (int k = 0; k < len; k++) begin
            a = cossim_pkg::ELEM_W'($urandom);
            b = cossim_pkg::ELEM_W'($urandom);
            case (pattern)
                VEC_SAME:     b = a;
                VEC_OPPOSITE: b = -a;
                VEC_TINY: begin
                    a = cossim_pkg::ELEM_W'($urandom_range(0, 8) - 4);
                    b = cossim_pkg::ELEM_W'($urandom_range(0, 8) - 4);
                end
                VEC_NEAR:     b = a + cossim_pkg::ELEM_W'($urandom_range(0, 512) - 256);
                VEC_EXTREME: begin
                    a = pick_extreme();
                    b = pick_extreme();
                end
                VEC_ZERO_A:   a = '0;
                VEC_ALL_MIN: begin
                    a = 16'sh8000;
                    b = 16'sh8000;
                end
                default: ;
            endcase
            send_pair(a, b, k == len - 1, 1'b0, '0);
        end
        vectors_sent++;
    endtask

    // Mostly short vectors, now and then a longer one
    task automatic random_phase(input int n_pairs);
        int start;
        int len;
        start = pairs_sent;
        while (pairs_sent - start < n_pairs) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 8);
            send_vector(len, $urandom_range(VEC_RANDOM, VEC_ALL_MIN));
        end
    endtask

    // Stop offering and wait until every pending result has arrived
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sim_expect_q.size() != 0);
    endtask

    initial begin
        req_if.valid     <= 1'b0;
        req_if.elem_a    <= '0;
        req_if.elem_b    <= '0;
        req_if.last_pair <= 1'b0;
        i_rst_n          <= 1'b0;
        clear_sums();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, then random under the first idle mix
        foreach (dir_rows[r]) begin
            send_pair(dir_rows[r].a, dir_rows[r].b, dir_rows[r].last,
                      dir_rows[r].fixed, dir_rows[r].res);
        end
        random_phase(PHASE_PAIRS);
        drain();

        // Swap the idle mix
        src_idle_pct  = 72;
        sink_idle_pct <= 28;
        random_phase(PHASE_PAIRS);
        drain();

        // No idling; hold the result side off while short vectors pile up
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        fork
            begin
                hold_sink <= 1'b1;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                hold_sink <= 1'b0;
            end
        join_none
        for (int v = 0; v < 40; v++) begin
            send_vector($urandom_range(1, 3), $urandom_range(VEC_RANDOM, VEC_ALL_MIN));
        end
        drain();
        random_phase(PHASE_PAIRS);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d pairs in %0d vectors under three idle mixes and a long result stall;",
                 pairs_sent, vectors_sent);
        $display("checked %0d results: %0d at unity, %0d at zero, %0d over the length limit.",
                 results_seen, unity_seen, zero_seen, over_len_seen);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/cossim_pkg.sv
rtl/core/cossim_if.sv
rtl/core/cossim_ctrl.sv
rtl/core/cossim_dp.sv
rtl/core/cosine_similarity_clamped.sv
rtl/core/cossim_checker.sv
bench/testbench.sv
